// ===== rtl/core/qocp_pkg.sv =====
// Package for the qualified object counter: payload types, constants, command struct.
`timescale 1ns / 1ps

package qocp_pkg;

    localparam int COUNT_W     = 10;
    localparam int COUNT_MAX   = 999;
    localparam int COUNT_LIMIT = (COUNT_MAX > (2 ** COUNT_W - 1)) ? (2 ** COUNT_W - 1)
                                                                  : COUNT_MAX;
    localparam int DIST_W      = 10;
    localparam int TIME_W      = 32;
    localparam int LOCK_W      = 16;
    localparam int PCT_W       = 7;
    localparam int PCT_MAX     = 100;

    // Quotient is below 128 whenever count < target, so 7 restoring steps suffice.
    localparam int DIV_STEPS   = PCT_W;
    localparam int DVD_W       = 17;   // holds count * 100 for a 10-bit count

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS   = 2'd3;

    localparam logic [COUNT_W-1:0] RST_TARGET_TOTAL = 10'd0;
    localparam logic [DIST_W-1:0]  RST_NEAR_THRESH  = 10'd10;
    localparam logic [LOCK_W-1:0]  RST_LOCKOUT_MS   = 16'd150;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [DIST_W-1:0] distance_first;
        logic [DIST_W-1:0] distance_second;
        logic [DIST_W-1:0] distance_third;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] object_count;
        logic [PCT_W-1:0]   pct_done;
        logic               counted;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the input transaction, update count and lockout
        logic step;     // one restoring division step
        logic load;     // move the finished result to the output register
    } t_cmd;

endpackage

// ===== rtl/core/qocp_ctrl.sv =====
// Controller FSM for the qualified object counter: sequencing and output valid.
`timescale 1ns / 1ps

module qocp_ctrl
    import qocp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step       = STEP_W'(DIV_STEPS - 1);
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV && r_step == STEP_W'(DIV_STEPS - 1)))
        else $error("accepted transaction did not start the division");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |=> (r_state == S_DONE))
        else $error("division did not finish after its last step");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not raise output valid");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.step, o_cmd.load}))
        else $error("more than one datapath command at once");

endmodule

// ===== rtl/core/qocp_dp.sv =====
// Datapath for the qualified object counter: config, count, lockout, divider, result.
`timescale 1ns / 1ps

module qocp_dp
    import qocp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_data,
    input  t_cmd                  i_cmd,
    output t_out                  o_data
);

    // Configuration registers
    logic [COUNT_W-1:0] r_target_total;
    logic               r_target_valid;
    logic [DIST_W-1:0]  r_near_thresh;
    logic [LOCK_W-1:0]  r_lockout_ms;

    // Block state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0]  r_lock_end, n_lock_end;
    logic               r_counted, n_counted;

    // Divider
    logic [DVD_W-1:0]   r_rem, r_dvs;
    logic [PCT_W-1:0]   r_quo;
    logic [DVD_W-1:0]   dividend;
    logic               rem_ge;

    t_out               r_out;
    logic               qualify;
    logic [PCT_W-1:0]   pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_total <= RST_TARGET_TOTAL;
            r_target_valid <= 1'b0;
            r_near_thresh  <= RST_NEAR_THRESH;
            r_lockout_ms   <= RST_LOCKOUT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_TOTAL: r_target_total <= i_cfg_data[COUNT_W-1:0];
                CFG_TARGET_VALID: r_target_valid <= i_cfg_data[0];
                CFG_NEAR_THRESH:  r_near_thresh  <= i_cfg_data[DIST_W-1:0];
                CFG_LOCKOUT_MS:   r_lockout_ms   <= i_cfg_data[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    assign qualify = (i_data.distance_first  < r_near_thresh) &&
                     (i_data.distance_second < r_near_thresh) &&
                     (i_data.distance_third  < r_near_thresh) &&
                     (i_data.now_ms > r_lock_end);

    always_comb begin
        n_count    = r_count;
        n_lock_end = r_lock_end;
        n_counted  = 1'b0;
        if (i_data.operation == OP_CLEAR) begin
            n_count = '0;
        end else if (qualify) begin
            if (r_count < COUNT_W'(COUNT_LIMIT)) begin
                n_count   = r_count + 1'b1;
                n_counted = 1'b1;
            end
            n_lock_end = i_data.now_ms + TIME_W'(r_lockout_ms);
        end
    end

    // count * 100 as shifts: 64 + 32 + 4
    assign dividend = (DVD_W'(n_count) << 6) + (DVD_W'(n_count) << 5) + (DVD_W'(n_count) << 2);
    assign rem_ge   = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_lock_end <= '0;
        end else if (i_cmd.accept) begin
            r_count    <= n_count;
            r_lock_end <= n_lock_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_counted <= n_counted;
            r_rem     <= dividend;
            r_dvs     <= DVD_W'(r_target_total) << (DIV_STEPS - 1);
            r_quo     <= '0;
        end else if (i_cmd.step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quo <= {r_quo[PCT_W-2:0], rem_ge};
            r_dvs <= r_dvs >> 1;
        end
    end

    // No target gives 0; count at or above target caps at 100.
    always_comb begin
        if (!r_target_valid || r_target_total == '0) begin
            pct = '0;
        end else if (r_count >= r_target_total) begin
            pct = PCT_W'(PCT_MAX);
        end else begin
            pct = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.object_count <= r_count;
            r_out.pct_done     <= pct;
            r_out.counted      <= r_counted;
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/core/qualified_object_counter_progress.sv =====
// Top level of the qualified object counter with progress percent.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one transaction per
//   sample or clear. A sample counts an object, up to a count of 999, when all three
//   distances are below the near threshold and now_ms is strictly past the stored
//   lockout end; the lockout end then moves to now_ms + lockout_ms (32-bit wrap).
//   A clear zeroes the count. Every input transaction yields exactly one output
//   transaction (o_out_valid / i_out_ready / o_out_data) with count, progress and
//   counted flag. o_out_valid rises once the 7 restoring division steps for the
//   percent are done and the result is loaded into the output register, when free.
//   A new input is taken only once the shared serial divider has finished and the
//   controller is back in idle; it is taken while the previous result still sits in
//   the output register. If the receiver stalls, the following result waits in the
//   datapath and input is held off until the output register frees. Configuration
//   (i_cfg_we / i_cfg_idx / i_cfg_data) writes one of target_total, target_valid,
//   near_threshold_cm and lockout_ms, selected by i_cfg_idx; write only while
//   idle. Reset (synchronous, active low) clears count and lockout end, restores
//   register defaults and drops the output valid.

module qualified_object_counter_progress
    import qocp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    qocp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    qocp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_in_data),
        .i_cmd      (cmd),
        .o_data     (o_out_data)
    );

endmodule
